FILE: rtl/sacl_pkg.sv
package sacl_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int WAYS = 4;
  localparam int ADDR_WIDTH = 64;

  // fixed field widths
  localparam int KIND_W = 2;
  localparam int IN_ADDR_W = 64;
  localparam int COUNT_W = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 6;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W = WAY_W;
  localparam int WAY_CNT_W = $clog2(WAYS + 1);
  localparam int TAG_W = ADDR_WIDTH;

  localparam logic [IN_ADDR_W-1:0] ADDR_MASK =
    (ADDR_WIDTH >= IN_ADDR_W) ? {IN_ADDR_W{1'b1}} :
    ((IN_ADDR_W'(1) << ADDR_WIDTH) - IN_ADDR_W'(1));

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_STORE  = 2'd1,
    KIND_MODIFY = 2'd2,
    KIND_OTHER  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OUT_HIT            = 3'd0,
    OUT_MISS           = 3'd1,
    OUT_MISS_HIT       = 3'd2,
    OUT_MISS_EVICT     = 3'd3,
    OUT_MISS_EVICT_HIT = 3'd4
  } outcome_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS_USED  = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [IN_ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    outcome_t             outcome;
    logic [COUNT_W-1:0]   hit_total;
    logic [COUNT_W-1:0]   miss_total;
    logic [COUNT_W-1:0]   evict_total;
  } out_item_t;

  typedef struct packed {
    logic [2:0] set_bits;
    logic [5:0] block_bits;
    logic [2:0] ways_used;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [RANK_W-1:0] rank;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic accept;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/set_assoc_cache_lru_sim_top.sv
// a result is registered in the output register when its item commits
// no new item is taken until the current one commits (one set read, then compare
//   and write back through the line memory); commits wait on a stalled output
// reset: synchronous, active high; empties all lines, zeroes the counters and
//   loads the default configuration, with no clearing pass
module set_assoc_cache_lru_sim_top
  import sacl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // item channel in
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  // result channel out
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  // configuration writes
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // configuration registers: the user must write them only while no item is in flight; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.set_bits   <= '0;
      cfg.block_bits <= '0;
      cfg.ways_used  <= 3'(WAYS);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SET_BITS:   cfg.set_bits   <= cfg_data[2:0];
        CFG_BLOCK_BITS: cfg.block_bits <= cfg_data[5:0];
        CFG_WAYS_USED:  cfg.ways_used  <= cfg_data[2:0];
        default: begin
          // unused index, nothing to write
        end
      endcase
    end
  end

  // sequencer: idle -> lookup, waits in lookup while the output is held
  sacl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // address split, line memory, way compare, recency update, counters
  sacl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/sacl_ram.sv
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/sacl_ctrl.sv
module sacl_ctrl
  import sacl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_LOOKUP = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // hold the set read until the output register can take the result
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/sacl_dp.sv
module sacl_dp
  import sacl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  in_item_t   in_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  // effective configuration
  logic [2:0]           sb_eff;
  logic [WAY_CNT_W-1:0] nw_eff;
  logic [WAYS-1:0]      in_use;

  // address split
  logic [IN_ADDR_W-1:0] addr_m;
  logic [IN_ADDR_W-1:0] addr_shifted;
  logic [6:0]           tag_shift;
  logic [IN_ADDR_W-1:0] tag_full;
  logic [SET_W-1:0]     set_mask;
  logic [SET_W-1:0]     set_idx;

  // captured at accept
  logic [TAG_W-1:0] tag_q;
  logic [SET_W-1:0] set_q;
  logic             modify_q;
  logic             row_seen_q;

  logic [NUM_SETS-1:0] row_seen;
  row_t                ram_rdata;
  row_t                row;
  row_t                row_next;

  // lookup
  logic             hit;
  logic             have_empty;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] empty_way;
  logic [WAY_W-1:0] evict_way;
  logic [WAY_W-1:0] target;
  logic [RANK_W-1:0] age_limit;
  outcome_t         outcome;

  logic [COUNT_W-1:0] hit_count;
  logic [COUNT_W-1:0] miss_count;
  logic [COUNT_W-1:0] evict_count;
  logic [COUNT_W-1:0] hit_count_next;
  logic [COUNT_W-1:0] miss_count_next;
  logic [COUNT_W-1:0] evict_count_next;

  always_comb begin
    if (int'(cfg.set_bits) > MAX_SET_BITS) begin
      sb_eff = 3'(MAX_SET_BITS);
    end else begin
      sb_eff = cfg.set_bits;
    end
    if (cfg.ways_used == 3'd0) begin
      nw_eff = WAY_CNT_W'(1);
    end else if (int'(cfg.ways_used) > WAYS) begin
      nw_eff = WAY_CNT_W'(WAYS);
    end else begin
      nw_eff = WAY_CNT_W'(cfg.ways_used);
    end
    for (int w = 0; w < WAYS; w++) begin
      in_use[w] = (w < int'(nw_eff));
    end
  end

  assign addr_m       = in_data.address & ADDR_MASK;
  assign addr_shifted = addr_m >> cfg.block_bits;
  assign tag_shift    = 7'(sb_eff) + 7'(cfg.block_bits);
  assign tag_full     = (tag_shift >= 7'(IN_ADDR_W)) ? '0 : (addr_m >> tag_shift[5:0]);
  assign set_mask     = ~({SET_W{1'b1}} << sb_eff);
  assign set_idx      = addr_shifted[SET_W-1:0] & set_mask;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tag_q      <= tag_full[TAG_W-1:0];
      set_q      <= set_idx;
      modify_q   <= (in_data.kind == KIND_MODIFY);
      row_seen_q <= row_seen[set_idx];
    end
  end

  // rows never written since reset read as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      row_seen <= '0;
    end else if (cmd.commit) begin
      row_seen[set_q] <= 1'b1;
    end
  end

  sacl_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (NUM_SETS)
  ) u_lines (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (set_q),
    .wdata (row_next),
    .re    (cmd.accept),
    .raddr (set_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    row = row_seen_q ? ram_rdata : '0;
    hit = 1'b0;
    have_empty = 1'b0;
    hit_way = '0;
    empty_way = '0;
    // scan downward so the lowest way wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (in_use[w] && row[w].valid && (row[w].tag == tag_q)) begin
        hit = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (in_use[w] && !row[w].valid) begin
        have_empty = 1'b1;
        empty_way = WAY_W'(w);
      end
    end
    evict_way = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (in_use[w] && (row[w].rank > row[evict_way].rank)) begin
        evict_way = WAY_W'(w);
      end
    end

    if (hit) begin
      target = hit_way;
    end else if (have_empty) begin
      target = empty_way;
    end else begin
      target = evict_way;
    end

    if (!hit && have_empty) begin
      age_limit = RANK_W'(WAYS - 1);
    end else begin
      age_limit = row[target].rank;
    end

    row_next = row;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == target) begin
        row_next[w].valid = 1'b1;
        row_next[w].tag   = tag_q;
        row_next[w].rank  = '0;
      end else if (in_use[w] && row[w].valid && (row[w].rank < age_limit)) begin
        row_next[w].rank = row[w].rank + RANK_W'(1);
      end
    end

    if (hit) begin
      outcome = OUT_HIT;
    end else if (have_empty) begin
      outcome = modify_q ? OUT_MISS_HIT : OUT_MISS;
    end else begin
      outcome = modify_q ? OUT_MISS_EVICT_HIT : OUT_MISS_EVICT;
    end

    if (hit) begin
      hit_count_next = hit_count + (modify_q ? COUNT_W'(2) : COUNT_W'(1));
    end else begin
      hit_count_next = hit_count + (modify_q ? COUNT_W'(1) : COUNT_W'(0));
    end
    miss_count_next  = hit ? miss_count : miss_count + COUNT_W'(1);
    evict_count_next = (!hit && !have_empty) ? evict_count + COUNT_W'(1) : evict_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count   <= '0;
      miss_count  <= '0;
      evict_count <= '0;
    end else if (cmd.commit) begin
      hit_count   <= hit_count_next;
      miss_count  <= miss_count_next;
      evict_count <= evict_count_next;
    end
  end

  // output register
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.outcome     <= outcome;
      out_data.hit_total   <= hit_count_next;
      out_data.miss_total  <= miss_count_next;
      out_data.evict_total <= evict_count_next;
    end
  end

endmodule

FILE: sim/set_assoc_cache_lru_sim_top_test.sv
`timescale 1ns / 1ps

module set_assoc_cache_lru_sim_top_test;
  import sacl_pkg::*;

  // cycles with no item moving on either channel before the run is declared hung
  localparam int WATCHDOG_LIMIT = 4000;
  // quiet cycles after the last result before a config write or the verdict
  localparam int SETTLE_CYCLES = 4;
  // length of the long output hold-off
  localparam int HOLD_CYCLES = 120;
  // random accesses run under each cache geometry
  localparam int ITEMS_PER_GEOMETRY = 158;

  // geometries walked by the random phases: set bits, block bits, ways in use
  // (set bits 7 and ways 0 / 7 land outside the legal range on purpose)
  localparam int GEO_SB [9] = '{0, 1, 2, 6, 7, 3, 4, 5, 2};
  localparam int GEO_BB [9] = '{0, 2, 4, 0, 5, 63, 58, 3, 6};
  localparam int GEO_WU [9] = '{4, 1, 2, 4, 3, 4, 0, 7, 4};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  set_assoc_cache_lru_sim_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow cache: our own copy of lines, ranks, totals and geometry registers
  // ---------------------------------------------------------------------------
  logic              shadow_valid [NUM_SETS*WAYS];
  logic [TAG_W-1:0]  shadow_tag   [NUM_SETS*WAYS];
  logic [RANK_W-1:0] shadow_rank  [NUM_SETS*WAYS];
  logic [COUNT_W-1:0] hit_tally = '0;
  logic [COUNT_W-1:0] miss_tally = '0;
  logic [COUNT_W-1:0] evict_tally = '0;
  logic [2:0] cfg_set_bits = 3'd0;
  logic [5:0] cfg_block_bits = 6'd0;
  logic [2:0] cfg_ways = 3'(WAYS);

  out_item_t      predicted_outcomes [$];
  logic [63:0]    recent_addrs [$];
  out_item_t      want_item;
  int             mismatch_count = 0;
  int             idle_cycles = 0;
  int             src_idle_pct = 0;
  int             sink_idle_pct = 0;
  int             hold_left = 0;
  int             hold_requests = 0;
  int             hold_served = 0;

  // set bits above the supported maximum act as the maximum
  function automatic int eff_set_bits();
    return (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_set_bits);
  endfunction

  // one access against the shadow cache: updates lines, ranks and totals and
  // returns the result the block should report
  function automatic out_item_t lru_lookup(in_item_t it);
    logic [63:0]       addr;
    logic [TAG_W-1:0]  tag;
    logic [RANK_W-1:0] old;
    int                sb, nw, n, set_idx, base, target, w;
    bit                hit, have_empty, modify;
    out_item_t         res;
    addr = it.address & ADDR_MASK;
    modify = (it.kind == KIND_MODIFY);
    sb = eff_set_bits();
    // ways in use: zero acts as one, above the array size acts as the size
    nw = (cfg_ways == 0) ? 1 : ((cfg_ways > WAYS) ? WAYS : int'(cfg_ways));
    n = sb + int'(cfg_block_bits);
    // tag shifted entirely out once index plus offset cover the address
    tag = (n >= 64) ? '0 : (addr >> n);
    set_idx = int'((addr >> cfg_block_bits) & ((64'd1 << sb) - 64'd1));
    base = set_idx * WAYS;
    hit = 1'b0;
    have_empty = 1'b0;
    target = 0;
    // lowest matching way wins
    for (w = 0; w < nw; w++) begin
      if (!hit && shadow_valid[base+w] && shadow_tag[base+w] == tag) begin
        hit = 1'b1;
        target = w;
      end
    end
    if (hit) begin
      old = shadow_rank[base+target];
      for (w = 0; w < nw; w++) begin
        if (w != target && shadow_valid[base+w] && shadow_rank[base+w] < old)
          shadow_rank[base+w]++;
      end
      shadow_rank[base+target] = '0;
      hit_tally += modify ? 2 : 1;
      res.outcome = OUT_HIT;
    end else begin
      miss_tally++;
      for (w = 0; w < nw; w++) begin
        if (!have_empty && !shadow_valid[base+w]) begin
          have_empty = 1'b1;
          target = w;
        end
      end
      if (have_empty) begin
        // fill ages every other live line, saturating at the oldest rank
        for (w = 0; w < nw; w++) begin
          if (w != target && shadow_valid[base+w] && shadow_rank[base+w] < WAYS-1)
            shadow_rank[base+w]++;
        end
        res.outcome = modify ? OUT_MISS_HIT : OUT_MISS;
      end else begin
        // victim: lowest way holding the largest rank
        target = 0;
        for (w = 1; w < nw; w++) begin
          if (shadow_rank[base+w] > shadow_rank[base+target])
            target = w;
        end
        old = shadow_rank[base+target];
        for (w = 0; w < nw; w++) begin
          if (w != target && shadow_valid[base+w] && shadow_rank[base+w] < old)
            shadow_rank[base+w]++;
        end
        evict_tally++;
        res.outcome = modify ? OUT_MISS_EVICT_HIT : OUT_MISS_EVICT;
      end
      shadow_valid[base+target] = 1'b1;
      shadow_tag[base+target] = tag;
      shadow_rank[base+target] = '0;
      if (modify)
        hit_tally++;
    end
    res.hit_total = hit_tally;
    res.miss_total = miss_tally;
    res.evict_total = evict_tally;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // input side: one item per call, entered and left at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_access(input kind_t k, input logic [63:0] a);
    in_item_t it;
    it.kind = k;
    it.address = a;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    predicted_outcomes.push_back(lru_lookup(it));
    recent_addrs.push_back(a);
    if (recent_addrs.size() > 16)
      void'(recent_addrs.pop_front());
    @(negedge clk);
  endtask

  // stop offering items and wait until every predicted result came back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (predicted_outcomes.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_SET_BITS:   cfg_set_bits = val[2:0];
      CFG_BLOCK_BITS: cfg_block_bits = val;
      CFG_WAYS_USED:  cfg_ways = val[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // drain, then load a new geometry; unused upper data bits carry noise
  task automatic set_geometry(input int sb, input int bb, input int wu);
    wait_for_results();
    write_reg(CFG_SET_BITS, {3'($urandom_range(0, 7)), 3'(sb)});
    write_reg(CFG_BLOCK_BITS, 6'(bb));
    write_reg(CFG_WAYS_USED, {3'($urandom_range(0, 7)), 3'(wu)});
  endtask

  // mostly addresses built from a small tag pool so sets see hits, fills and
  // evictions; the rest are repeats of recent addresses and raw 64-bit noise
  function automatic logic [63:0] pick_address();
    logic [63:0] tagv, setv, off;
    int          sb, bb, n, r;
    sb = eff_set_bits();
    bb = int'(cfg_block_bits);
    n = sb + bb;
    r = $urandom_range(0, 99);
    if (r < 15 && recent_addrs.size() > 0)
      return recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
    if (r < 30)
      return {$urandom, $urandom};
    tagv = 64'($urandom_range(0, 5));
    if ($urandom_range(0, 9) == 0)
      tagv = {$urandom, $urandom};
    setv = ($urandom_range(0, 4) == 0) ? 64'($urandom) : 64'($urandom_range(0, 3));
    setv &= (64'd1 << sb) - 64'd1;
    off = {$urandom, $urandom} & ((64'd1 << bb) - 64'd1);
    return ((n >= 64) ? 64'd0 : (tagv << n)) | (setv << bb) | off;
  endfunction

  // ---------------------------------------------------------------------------
  // output side: random stalls, or a long counted hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_left = HOLD_CYCLES;
      hold_served = hold_requests;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < sink_idle_pct);
    end
  end

  // result checking and hang watchdog, both on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end else if (out_valid && !out_stall) begin
        if (predicted_outcomes.size() == 0) begin
          $error("result item with no access pending");
          mismatch_count++;
        end else begin
          want_item = predicted_outcomes.pop_front();
          if (out_data.outcome !== want_item.outcome) begin
            $error("outcome: expected %0d, got %0d", want_item.outcome, out_data.outcome);
            mismatch_count++;
          end
          if (out_data.hit_total !== want_item.hit_total) begin
            $error("hit_total: expected %0d, got %0d",
                   want_item.hit_total, out_data.hit_total);
            mismatch_count++;
          end
          if (out_data.miss_total !== want_item.miss_total) begin
            $error("miss_total: expected %0d, got %0d",
                   want_item.miss_total, out_data.miss_total);
            mismatch_count++;
          end
          if (out_data.evict_total !== want_item.evict_total) begin
            $error("evict_total: expected %0d, got %0d",
                   want_item.evict_total, out_data.evict_total);
            mismatch_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset geometry: one set of four ways, tag is the whole address
  task automatic test_default_geometry();
    send_access(KIND_LOAD, 64'd0);                     // cold miss
    send_access(KIND_LOAD, 64'd0);                     // plain hit
    send_access(KIND_MODIFY, 64'd0);                   // modify hit counts two
    send_access(KIND_STORE, '1);                       // all-ones tag
    send_access(KIND_OTHER, 64'd1);                    // unknown kind acts as load
    send_access(KIND_MODIFY, 64'd2);                   // miss then hit, set now full
    send_access(KIND_LOAD, 64'd0);                     // touch makes line 0 newest
    send_access(KIND_LOAD, 64'd3);                     // evicts least recent line
    send_access(KIND_MODIFY, 64'd4);                   // miss evict hit
    send_access(KIND_STORE, 64'h8000_0000_0000_0000);  // top address bit
  endtask

  // out-of-range registers, shifts that swallow the tag or the index, unused
  // register index, and reconfiguration over live lines
  task automatic test_config_extremes();
    set_geometry(7, 63, 0);                            // acts as 6 set bits, 1 way
    send_access(KIND_LOAD, 64'd0);                     // old tag-0 line still there
    send_access(KIND_LOAD, 64'h8000_0000_0000_0000);   // set from top bit alone
    send_access(KIND_MODIFY, '1);
    set_geometry(6, 58, 7);                            // tag gone, ways clamp to 4
    send_access(KIND_STORE, 64'hFC00_0000_0000_0000);
    send_access(KIND_LOAD, 64'h0400_0000_0000_0000);
    send_access(KIND_OTHER, 64'h0000_0000_0000_0000);
    wait_for_results();
    write_reg(CFG_UNUSED, 6'h3F);                      // must change nothing
    send_access(KIND_LOAD, 64'h0400_0000_0000_0000);
    set_geometry(0, 0, 5);
    send_access(KIND_LOAD, 64'd3);
    send_access(KIND_MODIFY, 64'h5555_AAAA_5555_AAAA);
  endtask

  // random accesses over three geometries under one idling pattern
  task automatic test_random_phase(input int src_pct, input int sink_pct, input int first);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    for (int g = first; g < first + 3; g++) begin
      set_geometry(GEO_SB[g], GEO_BB[g], GEO_WU[g]);
      repeat (ITEMS_PER_GEOMETRY)
        send_access(kind_t'($urandom_range(0, 3)), pick_address());
    end
  endtask

  // receiver holds off for a long stretch while items keep coming, so the
  // block fills and stalls its input
  task automatic test_output_holdoff();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    set_geometry(2, 4, 4);
    @(posedge clk);
    hold_requests++;
    @(negedge clk);
    repeat (24)
      send_access(kind_t'($urandom_range(0, 3)), pick_address());
    wait_for_results();
  endtask

  initial begin
    for (int i = 0; i < NUM_SETS*WAYS; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_tag[i] = '0;
      shadow_rank[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_geometry();
    test_config_extremes();
    test_random_phase(33, 86, 0);
    test_random_phase(86, 33, 3);
    test_random_phase(0, 0, 6);
    test_output_holdoff();

    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && predicted_outcomes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
